// ===== src/efcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder frame check and unwrap package
// Shared widths, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package efcu_pkg;

  localparam int FRAME_BITS    = 16;
  localparam int ANGLE_BITS    = 14;
  localparam int POS_BITS      = 39;
  localparam int COUNT_BITS    = 32;
  localparam int OFFSET_BITS   = 32;
  localparam int JUMP_BITS     = 31;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  localparam int TURN_BITS_DEF  = 24;
  localparam int TALLY_BITS_DEF = 32;

  // Frame layout.
  localparam int PARITY_POS = 15;
  localparam int ERROR_POS  = 14;

  // A move of more than this many counts is taken as a wrap.
  localparam int HALF_TURN = 8192;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam logic [1:0] REG_MAX_JUMP  = 2'd2;

  localparam logic                          DIRECTION_RST = 1'b1;
  localparam logic signed [OFFSET_BITS-1:0] OFFSET_RST    = '0;
  localparam logic [JUMP_BITS-1:0]          MAX_JUMP_RST  = 31'd4096;

  typedef struct packed {
    logic                          direction_ccw;
    logic signed [OFFSET_BITS-1:0] offset_counts;
    logic [JUMP_BITS-1:0]          max_jump;
  } cfg_t;

endpackage

// ===== src/encoder_frame_check_and_unwrap_top.sv =====
// ----------------------------------------------------------------------------
// Encoder frame check and unwrap
// Checks 16-bit rotary encoder frames and unwraps the angle into a
// saturating multi-turn position with jump detection and error tallies.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ---------------------------------
//  in_      sink       in_valid/in_stall   response_word
//  out_     source     out_valid/out_stall angle, position, flags, tallies
//  cfg      APB slave  psel/penable/pready direction, offset, max jump
//
//  A beat is taken into an input register, worked on combinationally and
//  written into the result register, so one beat per cycle is sustained while
//  out_stall is low. out_valid rises when the beat moves on into the result
//  register, which waits while that register is full and out_stall is high.
//  The input register keeps taking beats while a result waits, until it is
//  itself full; only then does in_stall follow out_stall.
//  rst_n is synchronous and active low; it clears the unwrap state, the
//  tallies and the registers to their reset values, with no clearing pass.
//
module encoder_frame_check_and_unwrap_top #(
  parameter int TURN_BITS  = efcu_pkg::TURN_BITS_DEF,
  parameter int TALLY_BITS = efcu_pkg::TALLY_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Frame input
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [efcu_pkg::FRAME_BITS-1:0]          in_response_word,
  // Result output
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [efcu_pkg::ANGLE_BITS-1:0]          out_angle_counts,
  output logic signed [efcu_pkg::POS_BITS-1:0]     out_position,
  output logic                                    out_parity_bad,
  output logic                                    out_error_bit_set,
  output logic                                    out_jump_flag,
  output logic [efcu_pkg::COUNT_BITS-1:0]          out_parity_error_count,
  output logic [efcu_pkg::COUNT_BITS-1:0]          out_error_bit_count,
  output logic [efcu_pkg::COUNT_BITS-1:0]          out_jump_error_count,
  // Configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [efcu_pkg::CFG_ADDR_BITS-1:0]       paddr,
  input  logic [efcu_pkg::CFG_DATA_BITS-1:0]       pwdata,
  output logic [efcu_pkg::CFG_DATA_BITS-1:0]       prdata,
  output logic                                    pready
);
  import efcu_pkg::*;

  // Raw position {turn, angle} and the working width that holds its
  // negation and the offset subtraction without overflow.
  localparam int RAW_BITS = TURN_BITS + ANGLE_BITS;
  localparam int WORK_BITS = ((RAW_BITS > POS_BITS) ? RAW_BITS : POS_BITS) + 2;

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
  localparam logic signed [POS_BITS-1:0]  POS_MAX  = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0]  POS_MIN  = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic signed [ANGLE_BITS:0]  HALF_POS = (ANGLE_BITS+1)'(HALF_TURN);
  localparam logic signed [ANGLE_BITS:0]  HALF_NEG = -HALF_POS;

  cfg_t cfg;

  efcu_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic                  in_v_r;
  logic [FRAME_BITS-1:0] in_word_r;

  // Unwrap state. The last angle, last position and tallies are exactly
  // what the current result reports, so they drive the outputs directly.
  logic [ANGLE_BITS-1:0]        last_angle_r, last_angle_nxt;
  logic signed [TURN_BITS-1:0]  turn_r, turn_nxt;
  logic signed [POS_BITS-1:0]   last_pos_r, last_pos_nxt;
  logic [TALLY_BITS-1:0]        par_tally_r, par_tally_nxt;
  logic [TALLY_BITS-1:0]        err_tally_r, err_tally_nxt;
  logic [TALLY_BITS-1:0]        jmp_tally_r, jmp_tally_nxt;

  // Result flags.
  logic out_v_r;
  logic par_bad_r, par_bad_nxt;
  logic err_set_r, err_set_nxt;
  logic jump_r, jump_nxt;

  logic load;

  // A beat moves into the result register when the result register is
  // empty or is being drained in this cycle.
  assign load     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_response_word;
    end
  end

  // Per-frame datapath.
  logic signed [ANGLE_BITS:0]  delta;
  logic                        wrap_fwd, wrap_bwd;
  logic signed [RAW_BITS-1:0]  pos_raw;
  logic signed [WORK_BITS-1:0] pos_ext, pos_dir, pos_off;
  logic                        sat_hi, sat_lo;
  logic signed [POS_BITS:0]    diff;
  logic [POS_BITS:0]           diff_mag;

  always_comb begin
    par_bad_nxt    = (^in_word_r[PARITY_POS-1:0]) != in_word_r[PARITY_POS];
    err_set_nxt    = in_word_r[ERROR_POS];
    last_angle_nxt = in_word_r[ANGLE_BITS-1:0];

    // Wrap detection: a move of exactly half a turn does not count.
    delta    = $signed({1'b0, last_angle_nxt}) - $signed({1'b0, last_angle_r});
    wrap_fwd = delta > HALF_POS;
    wrap_bwd = delta < HALF_NEG;

    turn_nxt = turn_r;
    if (wrap_fwd && (turn_r != TURN_MIN)) begin
      turn_nxt = turn_r - TURN_BITS'(1);
    end else if (wrap_bwd && (turn_r != TURN_MAX)) begin
      turn_nxt = turn_r + TURN_BITS'(1);
    end

    // turn*16384 + angle is a plain concatenation since the angle is 14 bits.
    pos_raw = $signed({turn_nxt, last_angle_nxt});
    pos_ext = WORK_BITS'(pos_raw);
    pos_dir = cfg.direction_ccw ? -pos_ext : pos_ext;
    pos_off = pos_dir - WORK_BITS'(cfg.offset_counts);

    // Clamp into the 39-bit signed position range.
    sat_hi = !pos_off[WORK_BITS-1] && (|pos_off[WORK_BITS-2:POS_BITS-1]);
    sat_lo = pos_off[WORK_BITS-1] && !(&pos_off[WORK_BITS-2:POS_BITS-1]);
    if (sat_hi) begin
      last_pos_nxt = POS_MAX;
    end else if (sat_lo) begin
      last_pos_nxt = POS_MIN;
    end else begin
      last_pos_nxt = pos_off[POS_BITS-1:0];
    end

    diff     = $signed({last_pos_nxt[POS_BITS-1], last_pos_nxt})
             - $signed({last_pos_r[POS_BITS-1], last_pos_r});
    diff_mag = diff[POS_BITS] ? 
               (POS_BITS+1)'(-diff) : (POS_BITS+1)'(diff);
    jump_nxt = diff_mag > {{(POS_BITS+1-JUMP_BITS){1'b0}}, cfg.max_jump};

    par_tally_nxt = par_tally_r;
    err_tally_nxt = err_tally_r;
    jmp_tally_nxt = jmp_tally_r;
    if (par_bad_nxt && !(&par_tally_r)) begin
      par_tally_nxt = par_tally_r + TALLY_BITS'(1);
    end
    if (err_set_nxt && !(&err_tally_r)) begin
      err_tally_nxt = err_tally_r + TALLY_BITS'(1);
    end
    if (jump_nxt && !(&jmp_tally_r)) begin
      jmp_tally_nxt = jmp_tally_r + TALLY_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      last_angle_r <= '0;
      turn_r       <= '0;
      last_pos_r   <= '0;
      par_tally_r  <= '0;
      err_tally_r  <= '0;
      jmp_tally_r  <= '0;
    end else begin
      if (load) begin
        out_v_r      <= 1'b1;
        last_angle_r <= last_angle_nxt;
        turn_r       <= turn_nxt;
        last_pos_r   <= last_pos_nxt;
        par_tally_r  <= par_tally_nxt;
        err_tally_r  <= err_tally_nxt;
        jmp_tally_r  <= jmp_tally_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      par_bad_r <= par_bad_nxt;
      err_set_r <= err_set_nxt;
      jump_r    <= jump_nxt;
    end
  end

  assign out_valid              = out_v_r;
  assign out_angle_counts       = last_angle_r;
  assign out_position           = last_pos_r;
  assign out_parity_bad         = par_bad_r;
  assign out_error_bit_set      = err_set_r;
  assign out_jump_flag          = jump_r;
  assign out_parity_error_count = COUNT_BITS'(par_tally_r);
  assign out_error_bit_count    = COUNT_BITS'(err_tally_r);
  assign out_jump_error_count   = COUNT_BITS'(jmp_tally_r);

  // The input side only holds off when a beat is parked and the result
  // register cannot drain.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r))
    else $error("input stalled without a parked beat");

  // Every beat moved forward shows up as a valid result in the next cycle.
  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded beat did not produce a result");

  // The jump tally only moves on a loaded beat that is flagged as a jump.
  a_jump_tally_cause: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (jmp_tally_r != $past(jmp_tally_r))) |->
      ($past(load) && out_jump_flag))
    else $error("jump tally changed without a flagged jump");

endmodule

// ===== src/efcu_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Encoder frame check and unwrap configuration registers
// APB-style register file holding direction, offset and jump threshold.
// ----------------------------------------------------------------------------
module efcu_apb_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [efcu_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [efcu_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [efcu_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output efcu_pkg::cfg_t                    cfg
);
  import efcu_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction_ccw <= DIRECTION_RST;
      cfg_r.offset_counts <= OFFSET_RST;
      cfg_r.max_jump      <= MAX_JUMP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIRECTION: cfg_r.direction_ccw <= pwdata[0];
        REG_OFFSET:    cfg_r.offset_counts <= $signed(pwdata[OFFSET_BITS-1:0]);
        REG_MAX_JUMP:  cfg_r.max_jump      <= pwdata[JUMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIRECTION: prdata = {{(CFG_DATA_BITS-1){1'b0}}, cfg_r.direction_ccw};
      REG_OFFSET:    prdata = cfg_r.offset_counts;
      REG_MAX_JUMP:  prdata = {{(CFG_DATA_BITS-JUMP_BITS){1'b0}}, cfg_r.max_jump};
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
